@@ hw/rtl/mlhs_pkg.sv @@
// Package for the mailbox link handshake sequencer.
// Holds shared widths, transfer sizes, action codes, register indexes,
// reset values and wifi status codes. No dependencies.
`timescale 1ns / 1ps

package mlhs_pkg;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int STATE_W  = 4;
    localparam int WIFI_W   = 2;
    localparam int CNT_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Transfer sizes
    localparam int MAX_TRANSFER_DEF = 20;
    localparam int HEADER_BYTES     = 2;
    localparam int LEN_W_DEF        = $clog2(MAX_TRANSFER_DEF + 1);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DONE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_NOTIFY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PHASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PHASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_CODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_IP_CODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_NOTIFY  = 3'd5;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_MIN_PHASE    = 8'd5;
    localparam logic [BYTE_W-1:0] RST_MAX_PHASE    = 8'd20;
    localparam logic [BYTE_W-1:0] RST_IDLE_TIMEOUT = 8'd20;
    localparam logic [BYTE_W-1:0] RST_POLL_CODE    = 8'h00;
    localparam logic [BYTE_W-1:0] RST_SEND_IP_CODE = 8'h01;
    localparam logic [BYTE_W-1:0] RST_IDLE_NOTIFY  = 8'h00;

    // Wifi status codes
    localparam logic [WIFI_W-1:0] WIFI_DOWN    = 2'd0;
    localparam logic [WIFI_W-1:0] WIFI_UP      = 2'd1;
    localparam logic [WIFI_W-1:0] WIFI_UP_ADDR = 2'd2;

endpackage

@@ hw/rtl/mlhs_item_if.sv @@
// Input channel interface of the mailbox link handshake sequencer.
// Carries valid, ready and one input transaction; depends on mlhs_pkg.
`timescale 1ns / 1ps

interface mlhs_item_if;

    logic                            valid;
    logic                            ready;
    logic [mlhs_pkg::ACTION_W-1:0]   action;
    logic                            peer_mail;
    logic [mlhs_pkg::BYTE_W-1:0]     rx_type;
    logic [mlhs_pkg::BYTE_W-1:0]     rx_len;
    logic [mlhs_pkg::BYTE_W-1:0]     notify_type;

    modport source
    (
        output valid, action, peer_mail, rx_type, rx_len, notify_type,
        input  ready
    );

    modport sink
    (
        input  valid, action, peer_mail, rx_type, rx_len, notify_type,
        output ready
    );

endinterface

@@ hw/rtl/mlhs_result_if.sv @@
// Result channel interface of the mailbox link handshake sequencer.
// Carries valid, ready and one result transaction; depends on mlhs_pkg.
`timescale 1ns / 1ps

interface mlhs_result_if #(
    parameter int LEN_W = mlhs_pkg::LEN_W_DEF
);

    logic                            valid;
    logic                            ready;
    logic [mlhs_pkg::STATE_W-1:0]    link_state;
    logic                            mail_out;
    logic                            arm_transfer;
    logic [LEN_W-1:0]                transfer_len;
    logic                            length_error;
    logic [mlhs_pkg::BYTE_W-1:0]     response_type;
    logic                            payload_done;
    logic [mlhs_pkg::BYTE_W-1:0]     command_type;
    logic [mlhs_pkg::WIFI_W-1:0]     wifi_status;
    logic [mlhs_pkg::CNT_W-1:0]      unexpected_done_count;
    logic [mlhs_pkg::CNT_W-1:0]      idle_timeout_count;

    modport source
    (
        output valid, link_state, mail_out, arm_transfer, transfer_len, length_error,
               response_type, payload_done, command_type, wifi_status,
               unexpected_done_count, idle_timeout_count,
        input  ready
    );

    modport sink
    (
        input  valid, link_state, mail_out, arm_transfer, transfer_len, length_error,
               response_type, payload_done, command_type, wifi_status,
               unexpected_done_count, idle_timeout_count,
        output ready
    );

endinterface

@@ hw/rtl/mailbox_link_handshake_sequencer_core.sv @@
// Top level of the mailbox link handshake sequencer.
// Depends on mlhs_pkg, mlhs_item_if and mlhs_result_if.
`timescale 1ns / 1ps

// Accepts one transaction per clock while results are taken, and returns
// exactly one result transaction for each, in the cycle after acceptance.
// All link state is updated in the accepting cycle by a single pass of logic
// into the state registers, and the result lands in an output register; the
// input stays ready while that register is empty or is being drained, so the
// sustained rate is one transaction per clock. The wake pattern, header and
// payload handshake and error counters follow the configuration registers,
// which are to be written through cfg_we / cfg_index / cfg_data while the
// block is idle, a rule for the user that the block itself does not enforce;
// indexes past the last register are ignored. MAX_TRANSFER sets the largest
// payload accepted and the width of transfer_len.
module mailbox_link_handshake_sequencer_core #(
    parameter int MAX_TRANSFER = mlhs_pkg::MAX_TRANSFER_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mlhs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlhs_pkg::BYTE_W-1:0]      cfg_data,
    mlhs_item_if.sink                        item,
    mlhs_result_if.source                    result
);

    localparam int LEN_W = $clog2(MAX_TRANSFER + 1);
    localparam int BW    = mlhs_pkg::BYTE_W;
    localparam int SW    = mlhs_pkg::STATE_W;
    localparam int CW    = mlhs_pkg::CNT_W;

    // Link phase codes
    localparam logic [SW-1:0] PH_INVALID   = 4'd0;
    localparam logic [SW-1:0] PH_INIT      = 4'd1;
    localparam logic [SW-1:0] PH_UP1       = 4'd2;
    localparam logic [SW-1:0] PH_DOWN1     = 4'd3;
    localparam logic [SW-1:0] PH_UP2       = 4'd4;
    localparam logic [SW-1:0] PH_CONNECTED = 4'd5;
    localparam logic [SW-1:0] PH_HDR_BUSY  = 4'd6;
    localparam logic [SW-1:0] PH_HDR_DONE  = 4'd7;
    localparam logic [SW-1:0] PH_WAIT_PAY  = 4'd8;
    localparam logic [SW-1:0] PH_PAY_BUSY  = 4'd9;
    localparam logic [SW-1:0] PH_PAY_DONE  = 4'd10;
    localparam logic [SW-1:0] PH_WAIT_IDLE = 4'd11;

    localparam logic [BW-1:0]    TICK_MAX  = {BW{1'b1}};
    localparam logic [BW-1:0]    MAX_LEN   = BW'(MAX_TRANSFER);
    localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(mlhs_pkg::HEADER_BYTES);

    // Configuration registers
    logic [BW-1:0] min_phase_reg;
    logic [BW-1:0] max_phase_reg;
    logic [BW-1:0] idle_timeout_reg;
    logic [BW-1:0] poll_code_reg;
    logic [BW-1:0] send_ip_code_reg;
    logic [BW-1:0] idle_notify_reg;

    // Link state
    logic [SW-1:0] phase_reg,          phase_next;
    logic [BW-1:0] tick_count_reg,     tick_count_next;
    logic [BW-1:0] header_type_reg,    header_type_next;
    logic [BW-1:0] header_len_reg,     header_len_next;
    logic [BW-1:0] pending_notify_reg, pending_notify_next;
    logic          address_seen_reg,   address_seen_next;
    logic          mail_level_reg,     mail_level_next;
    logic [CW-1:0] done_errors_reg,    done_errors_next;
    logic [CW-1:0] timeout_errors_reg, timeout_errors_next;

    // Per-transaction result terms
    logic             arm;
    logic [LEN_W-1:0] tlen;
    logic             lerr;
    logic [BW-1:0]    resp;
    logic             pdone;
    logic [BW-1:0]    cmd;
    logic [mlhs_pkg::WIFI_W-1:0] wifi;

    logic [BW-1:0] tick_inc;
    logic          wake_in_bounds;

    // Output register
    logic                        out_valid_reg;
    logic [SW-1:0]               out_state_reg;
    logic                        out_mail_reg;
    logic                        out_arm_reg;
    logic [LEN_W-1:0]            out_len_reg;
    logic                        out_lerr_reg;
    logic [BW-1:0]               out_resp_reg;
    logic                        out_pdone_reg;
    logic [BW-1:0]               out_cmd_reg;
    logic [mlhs_pkg::WIFI_W-1:0] out_wifi_reg;
    logic [CW-1:0]               out_done_cnt_reg;
    logic [CW-1:0]               out_tmo_cnt_reg;

    logic accept;

    // Take a new transaction whenever the output slot is free or draining
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_phase_reg    <= mlhs_pkg::RST_MIN_PHASE;
            max_phase_reg    <= mlhs_pkg::RST_MAX_PHASE;
            idle_timeout_reg <= mlhs_pkg::RST_IDLE_TIMEOUT;
            poll_code_reg    <= mlhs_pkg::RST_POLL_CODE;
            send_ip_code_reg <= mlhs_pkg::RST_SEND_IP_CODE;
            idle_notify_reg  <= mlhs_pkg::RST_IDLE_NOTIFY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mlhs_pkg::REG_MIN_PHASE:    min_phase_reg    <= cfg_data;
                mlhs_pkg::REG_MAX_PHASE:    max_phase_reg    <= cfg_data;
                mlhs_pkg::REG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                mlhs_pkg::REG_POLL_CODE:    poll_code_reg    <= cfg_data;
                mlhs_pkg::REG_SEND_IP_CODE: send_ip_code_reg <= cfg_data;
                mlhs_pkg::REG_IDLE_NOTIFY:  idle_notify_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Saturating tick increment and wake phase length check
    assign tick_inc       = (tick_count_reg == TICK_MAX) ? tick_count_reg
                                                         : tick_count_reg + 1'b1;
    assign wake_in_bounds = (tick_count_reg >= min_phase_reg) &&
                            (tick_count_reg <= max_phase_reg);

    // Next state and result for one transaction
    always_comb
    begin
        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        header_type_next    = header_type_reg;
        header_len_next     = header_len_reg;
        pending_notify_next = pending_notify_reg;
        address_seen_next   = address_seen_reg;
        mail_level_next     = mail_level_reg;
        done_errors_next    = done_errors_reg;
        timeout_errors_next = timeout_errors_reg;
        arm   = 1'b0;
        tlen  = '0;
        lerr  = 1'b0;
        resp  = '0;
        pdone = 1'b0;
        cmd   = '0;

        unique case (item.action)
            mlhs_pkg::ACT_TICK:
            begin
                unique case (phase_reg)
                    PH_INVALID:
                    begin
                        if (!item.peer_mail)
                        begin
                            phase_next = PH_INIT;
                        end
                    end
                    PH_INIT:
                    begin
                        if (item.peer_mail)
                        begin
                            phase_next      = PH_UP1;
                            tick_count_next = '0;
                        end
                    end
                    PH_UP1, PH_DOWN1, PH_UP2:
                    begin
                        // Count while the level holds, judge the phase when it flips
                        if (item.peer_mail == (phase_reg != PH_DOWN1))
                        begin
                            tick_count_next = tick_inc;
                        end
                        else
                        begin
                            tick_count_next = '0;
                            if (wake_in_bounds)
                            begin
                                phase_next = phase_reg + 1'b1;
                                if (phase_reg == PH_UP2)
                                begin
                                    mail_level_next = 1'b0;
                                end
                            end
                            else
                            begin
                                phase_next = PH_INIT;
                            end
                        end
                    end
                    PH_CONNECTED:
                    begin
                        if (item.peer_mail)
                        begin
                            arm             = 1'b1;
                            tlen            = HDR_LEN;
                            mail_level_next = 1'b1;
                            phase_next      = PH_HDR_BUSY;
                        end
                    end
                    PH_HDR_DONE:
                    begin
                        mail_level_next = 1'b0;
                        phase_next      = PH_WAIT_PAY;
                    end
                    PH_WAIT_PAY:
                    begin
                        if (item.peer_mail)
                        begin
                            if (header_len_reg > MAX_LEN)
                            begin
                                // Oversized payload: flag it and drop the link
                                lerr            = 1'b1;
                                phase_next      = PH_INVALID;
                                mail_level_next = 1'b0;
                                tick_count_next = '0;
                            end
                            else
                            begin
                                if (header_type_reg == poll_code_reg)
                                begin
                                    resp                = pending_notify_reg;
                                    pending_notify_next = idle_notify_reg;
                                end
                                arm             = 1'b1;
                                tlen            = LEN_W'(header_len_reg);
                                mail_level_next = 1'b1;
                                phase_next      = PH_PAY_BUSY;
                            end
                        end
                    end
                    PH_PAY_DONE:
                    begin
                        if (header_type_reg == send_ip_code_reg)
                        begin
                            address_seen_next = 1'b1;
                        end
                        pdone           = 1'b1;
                        cmd             = header_type_reg;
                        mail_level_next = 1'b0;
                        phase_next      = PH_WAIT_IDLE;
                        tick_count_next = '0;
                    end
                    PH_WAIT_IDLE:
                    begin
                        if (!item.peer_mail)
                        begin
                            phase_next      = PH_CONNECTED;
                            tick_count_next = '0;
                        end
                        else if (tick_inc > idle_timeout_reg)
                        begin
                            // Peer held the line too long
                            timeout_errors_next = timeout_errors_reg + 1'b1;
                            phase_next          = PH_INVALID;
                            mail_level_next     = 1'b0;
                            tick_count_next     = '0;
                        end
                        else
                        begin
                            tick_count_next = tick_inc;
                        end
                    end
                    default:
                    begin
                        // Transfers in progress ignore ticks
                    end
                endcase
            end
            mlhs_pkg::ACT_DONE:
            begin
                if (phase_reg == PH_HDR_BUSY)
                begin
                    header_type_next = item.rx_type;
                    header_len_next  = item.rx_len;
                    phase_next       = PH_HDR_DONE;
                end
                else if (phase_reg == PH_PAY_BUSY)
                begin
                    phase_next = PH_PAY_DONE;
                end
                else
                begin
                    // Transfer-done outside a transfer
                    done_errors_next = done_errors_reg + 1'b1;
                    phase_next       = PH_INVALID;
                    mail_level_next  = 1'b0;
                    tick_count_next  = '0;
                end
            end
            mlhs_pkg::ACT_NOTIFY:
            begin
                pending_notify_next = item.notify_type;
            end
            default:
            begin
                // Unknown action leaves the state alone
            end
        endcase

        if (phase_next < PH_CONNECTED)
        begin
            wifi = mlhs_pkg::WIFI_DOWN;
        end
        else if (address_seen_next)
        begin
            wifi = mlhs_pkg::WIFI_UP_ADDR;
        end
        else
        begin
            wifi = mlhs_pkg::WIFI_UP;
        end
    end

    // Link state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_INVALID;
            tick_count_reg     <= '0;
            pending_notify_reg <= mlhs_pkg::RST_IDLE_NOTIFY;
            address_seen_reg   <= 1'b0;
            mail_level_reg     <= 1'b0;
            done_errors_reg    <= '0;
            timeout_errors_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            pending_notify_reg <= pending_notify_next;
            address_seen_reg   <= address_seen_next;
            mail_level_reg     <= mail_level_next;
            done_errors_reg    <= done_errors_next;
            timeout_errors_reg <= timeout_errors_next;
        end
    end

    // Header bytes are written before any read; no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            header_type_reg <= header_type_next;
            header_len_reg  <= header_len_next;
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_state_reg    <= phase_next;
            out_mail_reg     <= mail_level_next;
            out_arm_reg      <= arm;
            out_len_reg      <= tlen;
            out_lerr_reg     <= lerr;
            out_resp_reg     <= resp;
            out_pdone_reg    <= pdone;
            out_cmd_reg      <= cmd;
            out_wifi_reg     <= wifi;
            out_done_cnt_reg <= done_errors_next;
            out_tmo_cnt_reg  <= timeout_errors_next;
        end
    end

    assign result.valid                 = out_valid_reg;
    assign result.link_state            = out_state_reg;
    assign result.mail_out              = out_mail_reg;
    assign result.arm_transfer          = out_arm_reg;
    assign result.transfer_len          = out_len_reg;
    assign result.length_error          = out_lerr_reg;
    assign result.response_type         = out_resp_reg;
    assign result.payload_done          = out_pdone_reg;
    assign result.command_type          = out_cmd_reg;
    assign result.wifi_status           = out_wifi_reg;
    assign result.unexpected_done_count = out_done_cnt_reg;
    assign result.idle_timeout_count    = out_tmo_cnt_reg;

endmodule

@@ bench/mailbox_link_handshake_sequencer_core_test.sv @@
// Self-checking testbench for mailbox_link_handshake_sequencer_core.
// Runs a directed script and then random wake, header and payload sessions, and
// checks each result transaction against a cycle-free model of the link sequencer.
`timescale 1ns / 1ps

module mailbox_link_handshake_sequencer_core_test;

    localparam int LEN_W       = mlhs_pkg::LEN_W_DEF;
    localparam int CYCLE_LIMIT = 400000;

    // Codes the package leaves unnamed
    localparam logic [mlhs_pkg::ACTION_W-1:0]  ACT_SPARE    = 2'd3;
    localparam logic [mlhs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [mlhs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic [mlhs_pkg::STATE_W-1:0] {
        LINK_INVALID   = 4'd0,
        LINK_INIT      = 4'd1,
        LINK_UP1       = 4'd2,
        LINK_DOWN1     = 4'd3,
        LINK_UP2       = 4'd4,
        LINK_CONNECTED = 4'd5,
        LINK_HDR_BUSY  = 4'd6,
        LINK_HDR_DONE  = 4'd7,
        LINK_WAIT_PAY  = 4'd8,
        LINK_PAY_BUSY  = 4'd9,
        LINK_PAY_DONE  = 4'd10,
        LINK_WAIT_IDLE = 4'd11
    } link_phase_t;

    typedef struct packed {
        logic [mlhs_pkg::ACTION_W-1:0] action;
        logic                          peer;
        logic [mlhs_pkg::BYTE_W-1:0]   rx_type;
        logic [mlhs_pkg::BYTE_W-1:0]   rx_len;
        logic [mlhs_pkg::BYTE_W-1:0]   note;
    } link_item_t;

    typedef struct packed {
        logic [mlhs_pkg::STATE_W-1:0] link_state;
        logic                         mail_out;
        logic                         arm_transfer;
        logic [LEN_W-1:0]             transfer_len;
        logic                         length_error;
        logic [mlhs_pkg::BYTE_W-1:0]  response_type;
        logic                         payload_done;
        logic [mlhs_pkg::BYTE_W-1:0]  command_type;
        logic [mlhs_pkg::WIFI_W-1:0]  wifi_status;
        logic [mlhs_pkg::CNT_W-1:0]   unexpected_done_count;
        logic [mlhs_pkg::CNT_W-1:0]   idle_timeout_count;
    } link_result_t;

    typedef struct packed {
        logic [mlhs_pkg::ACTION_W-1:0] action;
        logic                          peer;
        logic [mlhs_pkg::BYTE_W-1:0]   rx_type;
        logic [mlhs_pkg::BYTE_W-1:0]   rx_len;
        logic [mlhs_pkg::BYTE_W-1:0]   note;
        logic                          typed;
        logic [mlhs_pkg::STATE_W-1:0]  want_state;
        logic [mlhs_pkg::CNT_W-1:0]    want_done_errs;
    } script_row_t;

    // Directed script, run with min 1, max 2, idle timeout 1, poll 0x00, send-ip 0xFF.
    // Only the opening rows carry a typed expectation; the rest go through the model.
    localparam script_row_t SCRIPT [23] = '{
        // action               peer  type   len    note   typed state         done errs
        '{mlhs_pkg::ACT_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 1'b1, LINK_INIT,    16'd0},
        '{mlhs_pkg::ACT_DONE,   1'b0, 8'hFF, 8'hFF, 8'h00, 1'b1, LINK_INVALID, 16'd1},
        '{ACT_SPARE,            1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, LINK_INVALID, 16'd1},
        '{mlhs_pkg::ACT_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        // first high phase too short: back to init
        '{mlhs_pkg::ACT_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_NOTIFY, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        // tick while the header transfer is busy: ignored
        '{mlhs_pkg::ACT_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_DONE,   1'b0, 8'h00, 8'h14, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_DONE,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        // peer holds its line past the idle timeout
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0},
        '{mlhs_pkg::ACT_TICK,   1'b1, 8'h00, 8'h00, 8'h00, 1'b0, LINK_INVALID, 16'd0}
    };

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [mlhs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mlhs_pkg::BYTE_W-1:0]    cfg_data;

    mlhs_item_if                     item_if ();
    mlhs_result_if #(.LEN_W(LEN_W))  res_if ();

    mailbox_link_handshake_sequencer_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_if),
        .result    (res_if)
    );

    // Model state and its copy of the configuration
    link_phase_t                 ph;
    logic [mlhs_pkg::BYTE_W-1:0] tick_cnt, hdr_type, hdr_len, pending_note;
    logic                        addr_seen, mail_lvl;
    logic [mlhs_pkg::CNT_W-1:0]  done_errs, timeout_errs;
    logic [mlhs_pkg::BYTE_W-1:0] cfg_min, cfg_max, cfg_idle_to, cfg_poll, cfg_sendip;
    logic [mlhs_pkg::BYTE_W-1:0] cfg_idle_note;

    link_result_t awaited_reports [$];
    int unsigned  fault_count = 0;
    int unsigned  items_sent = 0;
    int unsigned  cycle_count = 0;
    int unsigned  long_left = 0;
    int unsigned  hold_left = 0;
    bit           hold_req = 1'b0;
    bit           hold_taken = 1'b0;
    bit           calm = 1'b0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL mailbox_link_handshake_sequencer_core");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Link sequencer model
    // ---------------------------------------------------------------

    function automatic void bump_ticks();
        if (tick_cnt != 8'hFF)
            tick_cnt = tick_cnt + 8'd1;
    endfunction

    function automatic void drop_link();
        ph       = LINK_INVALID;
        mail_lvl = 1'b0;
        tick_cnt = '0;
    endfunction

    // Close a wake phase: advance if its length was in bounds, else restart
    function automatic void close_wake(input link_phase_t nxt);
        if (tick_cnt >= cfg_min && tick_cnt <= cfg_max)
        begin
            ph = nxt;
            if (nxt == LINK_CONNECTED)
                mail_lvl = 1'b0;
        end
        else
            ph = LINK_INIT;
        tick_cnt = '0;
    endfunction

    function automatic link_result_t advance_link(input link_item_t it);
        link_result_t r;
        r = '0;
        case (it.action)
            mlhs_pkg::ACT_TICK:
                case (ph)
                    LINK_INVALID:
                        if (!it.peer)
                            ph = LINK_INIT;
                    LINK_INIT:
                        if (it.peer)
                        begin
                            ph       = LINK_UP1;
                            tick_cnt = '0;
                        end
                    LINK_UP1:
                        if (it.peer) bump_ticks(); else close_wake(LINK_DOWN1);
                    LINK_DOWN1:
                        if (!it.peer) bump_ticks(); else close_wake(LINK_UP2);
                    LINK_UP2:
                        if (it.peer) bump_ticks(); else close_wake(LINK_CONNECTED);
                    LINK_CONNECTED:
                        if (it.peer)
                        begin
                            r.arm_transfer = 1'b1;
                            r.transfer_len = LEN_W'(mlhs_pkg::HEADER_BYTES);
                            mail_lvl       = 1'b1;
                            ph             = LINK_HDR_BUSY;
                        end
                    LINK_HDR_DONE:
                    begin
                        mail_lvl = 1'b0;
                        ph       = LINK_WAIT_PAY;
                    end
                    LINK_WAIT_PAY:
                        if (it.peer)
                        begin
                            if (hdr_len > mlhs_pkg::MAX_TRANSFER_DEF)
                            begin
                                r.length_error = 1'b1;
                                drop_link();
                            end
                            else
                            begin
                                // A poll takes the pending notification and resets it to the idle code
                                if (hdr_type == cfg_poll)
                                begin
                                    r.response_type = pending_note;
                                    pending_note    = cfg_idle_note;
                                end
                                r.arm_transfer = 1'b1;
                                r.transfer_len = hdr_len[LEN_W-1:0];
                                mail_lvl       = 1'b1;
                                ph             = LINK_PAY_BUSY;
                            end
                        end
                    LINK_PAY_DONE:
                    begin
                        if (hdr_type == cfg_sendip)
                            addr_seen = 1'b1;
                        r.payload_done = 1'b1;
                        r.command_type = hdr_type;
                        mail_lvl       = 1'b0;
                        ph             = LINK_WAIT_IDLE;
                        tick_cnt       = '0;
                    end
                    LINK_WAIT_IDLE:
                        if (!it.peer)
                        begin
                            ph       = LINK_CONNECTED;
                            tick_cnt = '0;
                        end
                        else
                        begin
                            bump_ticks();
                            if (tick_cnt > cfg_idle_to)
                            begin
                                timeout_errs = timeout_errs + 1'b1;
                                drop_link();
                            end
                        end
                    default:
                        ;
                endcase
            mlhs_pkg::ACT_DONE:
                if (ph == LINK_HDR_BUSY)
                begin
                    hdr_type = it.rx_type;
                    hdr_len  = it.rx_len;
                    ph       = LINK_HDR_DONE;
                end
                else if (ph == LINK_PAY_BUSY)
                    ph = LINK_PAY_DONE;
                else
                begin
                    done_errs = done_errs + 1'b1;
                    drop_link();
                end
            mlhs_pkg::ACT_NOTIFY:
                pending_note = it.note;
            default:
                ;
        endcase

        r.link_state            = ph;
        r.mail_out              = mail_lvl;
        r.wifi_status           = (ph < LINK_CONNECTED) ? mlhs_pkg::WIFI_DOWN :
                                  (addr_seen ? mlhs_pkg::WIFI_UP_ADDR : mlhs_pkg::WIFI_UP);
        r.unexpected_done_count = done_errs;
        r.idle_timeout_count    = timeout_errs;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name,
                                        input logic [mlhs_pkg::CNT_W-1:0] want,
                                        input logic [mlhs_pkg::CNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    function automatic void check_report();
        link_result_t want;
        if (awaited_reports.size() == 0)
        begin
            $error("result transaction with none outstanding");
            fault_count++;
            return;
        end
        want = awaited_reports.pop_front();
        check_field("link_state", want.link_state, res_if.link_state);
        check_field("mail_out", want.mail_out, res_if.mail_out);
        check_field("arm_transfer", want.arm_transfer, res_if.arm_transfer);
        check_field("transfer_len", want.transfer_len, res_if.transfer_len);
        check_field("length_error", want.length_error, res_if.length_error);
        check_field("response_type", want.response_type, res_if.response_type);
        check_field("payload_done", want.payload_done, res_if.payload_done);
        check_field("command_type", want.command_type, res_if.command_type);
        check_field("wifi_status", want.wifi_status, res_if.wifi_status);
        check_field("unexpected_done_count", want.unexpected_done_count,
                    res_if.unexpected_done_count);
        check_field("idle_timeout_count", want.idle_timeout_count,
                    res_if.idle_timeout_count);
    endfunction

    // Result side: check each transaction, then pick the next ready level
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                check_report();
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    task automatic write_reg(input logic [mlhs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mlhs_pkg::BYTE_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            mlhs_pkg::REG_MIN_PHASE:    cfg_min       = val;
            mlhs_pkg::REG_MAX_PHASE:    cfg_max       = val;
            mlhs_pkg::REG_IDLE_TIMEOUT: cfg_idle_to   = val;
            mlhs_pkg::REG_POLL_CODE:    cfg_poll      = val;
            mlhs_pkg::REG_SEND_IP_CODE: cfg_sendip    = val;
            mlhs_pkg::REG_IDLE_NOTIFY:  cfg_idle_note = val;
            default:                    ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_link(input logic [mlhs_pkg::BYTE_W-1:0] min_t, max_t, idle_t,
                                input logic [mlhs_pkg::BYTE_W-1:0] poll, sendip, idle_note);
        write_reg(mlhs_pkg::REG_MIN_PHASE, min_t);
        write_reg(mlhs_pkg::REG_MAX_PHASE, max_t);
        write_reg(mlhs_pkg::REG_IDLE_TIMEOUT, idle_t);
        write_reg(mlhs_pkg::REG_POLL_CODE, poll);
        write_reg(mlhs_pkg::REG_SEND_IP_CODE, sendip);
        write_reg(mlhs_pkg::REG_IDLE_NOTIFY, idle_note);
    endtask

    // Offer one transaction, with random gaps, and record its expected result
    task automatic offer(input link_item_t it, input bit typed, input link_result_t want);
        link_result_t predicted;
        while (!calm && $urandom_range(99) < 37)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.action      <= it.action;
        item_if.peer_mail   <= it.peer;
        item_if.rx_type     <= it.rx_type;
        item_if.rx_len      <= it.rx_len;
        item_if.notify_type <= it.note;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        predicted = advance_link(it);
        awaited_reports.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    function automatic link_item_t tick_item(input logic peer);
        return '{mlhs_pkg::ACT_TICK, peer, 8'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    function automatic link_item_t done_item(input logic [mlhs_pkg::BYTE_W-1:0] t, l);
        return '{mlhs_pkg::ACT_DONE, 1'($urandom_range(1)), t, l, 8'($urandom)};
    endfunction

    function automatic link_item_t note_item();
        return '{mlhs_pkg::ACT_NOTIFY, 1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                 8'($urandom)};
    endfunction

    // Occasionally slip in a random transaction that may break the sequence
    task automatic feed(input link_item_t it);
        link_item_t noise;
        if ($urandom_range(99) < 4)
        begin
            noise = '{2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom),
                      8'($urandom), 8'($urandom)};
            offer(noise, 1'b0, '0);
        end
        offer(it, 1'b0, '0);
    endtask

    // Extra ticks for one wake phase: mostly in bounds, sometimes not, never if min > 16
    function automatic int unsigned pick_len();
        int unsigned span;
        if (cfg_min > 16)
            return $urandom_range(5);
        if (long_left > 0 && cfg_max >= 200)
        begin
            long_left--;
            return 256;
        end
        span = (cfg_max > cfg_min) ? cfg_max - cfg_min : 0;
        if (span > 6)
            span = 6;
        if ($urandom_range(99) < 80 || (cfg_min == 0 && cfg_max > 16))
            return cfg_min + $urandom_range(span);
        if (cfg_max < 16 && (cfg_min == 0 || $urandom_range(1) == 1))
            return cfg_max + 1 + $urandom_range(2);
        return $urandom_range(cfg_min - 1);
    endfunction

    // Drive the wake pattern: high, low, high, then low to connect
    task automatic wake_attempt();
        logic lvl;
        int unsigned k;
        feed(tick_item(1'b0));
        feed(tick_item(1'b1));
        lvl = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            k = pick_len();
            repeat (k) feed(tick_item(lvl));
            feed(tick_item(!lvl));
            lvl = !lvl;
        end
    endtask

    // One header plus payload exchange, then the wait for the peer to go idle
    task automatic transfer();
        logic [mlhs_pkg::BYTE_W-1:0] t, l;
        int unsigned j;
        bit late;
        if ($urandom_range(99) < 40)
            feed(note_item());
        repeat ($urandom_range(2)) feed(tick_item(1'b0));
        feed(tick_item(1'b1));
        if ($urandom_range(3) == 0)
            feed(tick_item(1'($urandom_range(1))));
        case ($urandom_range(9))
            0, 1, 2: t = cfg_poll;
            3, 4:    t = cfg_sendip;
            default: t = 8'($urandom);
        endcase
        l = ($urandom_range(99) < 85) ? 8'($urandom_range(20)) : 8'($urandom_range(255, 21));
        feed(done_item(t, l));
        feed(tick_item(1'($urandom_range(1))));
        repeat ($urandom_range(1)) feed(tick_item(1'b0));
        if ($urandom_range(4) == 0)
            feed(note_item());
        feed(tick_item(1'b1));
        if (ph != LINK_PAY_BUSY)
            return;
        if ($urandom_range(3) == 0)
            feed(tick_item(1'($urandom_range(1))));
        feed(done_item(8'($urandom), 8'($urandom)));
        feed(tick_item(1'($urandom_range(1))));
        // Peer drops its line in time, or holds it past the timeout
        if (cfg_idle_to <= 8)
            late = ($urandom_range(99) < 30);
        else
            late = (long_left > 0 && $urandom_range(3) == 0);
        if (late)
        begin
            if (cfg_idle_to > 8)
                long_left--;
            repeat (cfg_idle_to + 1) feed(tick_item(1'b1));
        end
        else
        begin
            j = $urandom_range((cfg_idle_to < 4) ? cfg_idle_to : 4);
            repeat (j) feed(tick_item(1'b1));
            feed(tick_item(1'b0));
        end
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned target;
        target = items_sent + budget;
        while (items_sent < target)
        begin
            if (ph < LINK_CONNECTED)
                wake_attempt();
            else
                transfer();
        end
        item_if.valid <= 1'b0;
    endtask

    // Wait until every expected result is back and the block is quiet
    task automatic settle();
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        link_item_t   it;
        link_result_t want;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        item_if.valid       = 1'b0;
        item_if.action      = mlhs_pkg::ACT_TICK;
        item_if.peer_mail   = 1'b0;
        item_if.rx_type     = '0;
        item_if.rx_len      = '0;
        item_if.notify_type = '0;
        res_if.ready        = 1'b0;

        // Model reset
        ph            = LINK_INVALID;
        tick_cnt      = '0;
        hdr_type      = '0;
        hdr_len       = '0;
        pending_note  = mlhs_pkg::RST_IDLE_NOTIFY;
        addr_seen     = 1'b0;
        mail_lvl      = 1'b0;
        done_errs     = '0;
        timeout_errs  = '0;
        cfg_min       = mlhs_pkg::RST_MIN_PHASE;
        cfg_max       = mlhs_pkg::RST_MAX_PHASE;
        cfg_idle_to   = mlhs_pkg::RST_IDLE_TIMEOUT;
        cfg_poll      = mlhs_pkg::RST_POLL_CODE;
        cfg_sendip    = mlhs_pkg::RST_SEND_IP_CODE;
        cfg_idle_note = mlhs_pkg::RST_IDLE_NOTIFY;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short phases for the directed script; spare indexes must be ignored
        program_link(8'd1, 8'd2, 8'd1, 8'h00, 8'hFF, 8'hA5);
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h00);

        foreach (SCRIPT[i])
        begin
            it   = '{SCRIPT[i].action, SCRIPT[i].peer, SCRIPT[i].rx_type,
                     SCRIPT[i].rx_len, SCRIPT[i].note};
            want = '0;
            want.link_state            = SCRIPT[i].want_state;
            want.unexpected_done_count = SCRIPT[i].want_done_errs;
            offer(it, SCRIPT[i].typed, want);
        end
        item_if.valid <= 1'b0;
        settle();

        // Default settings, with a long stall on the result side
        program_link(mlhs_pkg::RST_MIN_PHASE, mlhs_pkg::RST_MAX_PHASE,
                     mlhs_pkg::RST_IDLE_TIMEOUT, mlhs_pkg::RST_POLL_CODE,
                     mlhs_pkg::RST_SEND_IP_CODE, mlhs_pkg::RST_IDLE_NOTIFY);
        hold_req = 1'b1;
        random_phase(180);
        settle();

        // Zero-length phases and timeout, no idling on either side
        program_link(8'd0, 8'd0, 8'd0, 8'hFF, 8'h00, 8'hFF);
        calm = 1'b1;
        random_phase(180);
        settle();
        calm = 1'b0;

        // Widest bounds, with a saturating count and a long timeout
        program_link(8'd0, 8'd254, 8'd254, 8'h5A, 8'hA5, 8'h3C);
        long_left = 2;
        random_phase(200);
        settle();

        // Minimum out of reach: wake attempts always restart
        program_link(8'd254, 8'd254, 8'd3, 8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(60);
        settle();

        // Random small settings with colliding command codes
        repeat (2)
        begin
            cfg_min = 8'($urandom_range(4));
            program_link(cfg_min, cfg_min + 8'($urandom_range(5)), 8'($urandom_range(6)),
                         8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom));
            random_phase(75);
            settle();
        end

        if (fault_count == 0)
            $display("PASS mailbox_link_handshake_sequencer_core");
        else
            $display("FAIL mailbox_link_handshake_sequencer_core");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mlhs_pkg.sv
hw/rtl/mlhs_item_if.sv
hw/rtl/mlhs_result_if.sv
hw/rtl/mailbox_link_handshake_sequencer_core.sv
bench/mailbox_link_handshake_sequencer_core_test.sv
